// ===== sv/buddy_page_allocator_defines.svh =====
// assertion macros for the buddy page allocator
`ifndef BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BPA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BPA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bpa_pkg.sv =====
// shared types, codes and helpers of the buddy page allocator
package bpa_pkg;

  localparam int OP_W     = 2;
  localparam int COUNT_W  = 13;
  localparam int ADDR_W   = 64;
  localparam int STATUS_W = 3;
  localparam int ORDER_W  = 4;

  typedef enum logic [OP_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    S_OK       = 3'd0,
    S_ZERO     = 3'd1,
    S_ORDER    = 3'd2,
    S_OOM      = 3'd3,
    S_NULL     = 3'd4,
    S_MISALIGN = 3'd5,
    S_OUTSIDE  = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    IDLE,
    DECODE,
    INIT_RUN,
    A_POP,
    A_SPLIT,
    F_START,
    F_CHECK,
    F_NEXT,
    F_UNLINK,
    DONE
  } state_t;

  // ceil(log2(n)), zero for n of zero or one
  function automatic logic [4:0] order_of(input logic [COUNT_W-1:0] n);
    logic [4:0] ord;
    ord = '0;
    for (int k = 0; k < COUNT_W; k++) begin
      if ({1'b0, n} > (14'd1 << k)) ord = 5'(k + 1);
    end
    return ord;
  endfunction

endpackage

// ===== sv/bpa_link_ram.sv =====
// link memory: one next-page pointer per page, registered read
module bpa_link_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 12
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/buddy_page_allocator.sv =====
// Buddy page allocator: one item (init, alloc or free) at a time, one result per item.
// The free-list links live in a one-write, one-read link memory with a registered read,
// so every list step costs one memory read. Init lays down one block per step; alloc
// pops a block and splits it one level per step; free walks the free list of each order
// for the buddy, merging one level per buddy found, until the buddy is not in the list
// or the top order is reached. The walk visits at most that order's free count. The
// next item can be taken in the cycle after the result is loaded. A result can wait in
// the output register while the block returns to idle; a second result waits in the block
// until the first one is taken. Link memory contents need no clearing after reset, so
// the block is ready right out of reset.
`include "buddy_page_allocator_defines.svh"

module buddy_page_allocator #(
  parameter int MAX_ORDER_VALUE = 10,
  parameter int MAX_PAGES       = 4096,
  parameter int PAGE_BYTES      = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  // input item
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bpa_pkg::OP_W-1:0]        operation,
  input  logic [bpa_pkg::COUNT_W-1:0]     page_count,
  input  logic [bpa_pkg::ADDR_W-1:0]      address,
  // result item
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bpa_pkg::STATUS_W-1:0]    status,
  output logic [bpa_pkg::ADDR_W-1:0]      block_address,
  output logic [bpa_pkg::ORDER_W-1:0]     block_order,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [0:0]                      paddr,
  input  logic [63:0]                     pwdata,
  output logic [63:0]                     prdata,
  output logic                            pready
);
  import bpa_pkg::*;

  localparam int PW  = $clog2(MAX_PAGES);
  localparam int CW  = $clog2(MAX_PAGES + 1);
  localparam int OW  = $clog2(MAX_ORDER_VALUE + 1);
  localparam int SW  = ((PW > MAX_ORDER_VALUE) ? PW : MAX_ORDER_VALUE) + 1;
  localparam int WW  = (CW > MAX_ORDER_VALUE + 1) ? CW : MAX_ORDER_VALUE + 1;
  localparam int PBW = $clog2(PAGE_BYTES);

  state_t st, st_next;

  // configuration register
  logic [ADDR_W-1:0] region_base;
  logic              cfg_we;

  // list state
  logic [PW-1:0] hd  [MAX_ORDER_VALUE+1];
  logic [CW-1:0] cnt [MAX_ORDER_VALUE+1];
  logic [CW-1:0] region_pages;

  // item registers
  logic [OP_W-1:0]    op;
  logic [COUNT_W-1:0] n;
  logic [ADDR_W-1:0]  addr;
  logic [CW-1:0]      ninit;
  logic [CW-1:0]      idx;
  logic [OW-1:0]      ord;
  logic [OW-1:0]      c;
  logic [SW-1:0]      page;
  logic [PW-1:0]      cur;
  logic [PW-1:0]      prev;
  logic [CW-1:0]      wi;
  status_t            res_status;
  logic [ADDR_W-1:0]  res_addr;
  logic [ORDER_W-1:0] res_order;

  // link memory ports
  logic          ram_we;
  logic [PW-1:0] ram_waddr, ram_wdata, ram_raddr, ram_rdata;

  // list update controls
  logic          push_en;
  logic [PW-1:0] push_page;
  logic [OW-1:0] push_ord;
  logic          hd_set;
  logic [PW-1:0] hd_val;
  logic          cnt_dec;
  logic          clear_all;

  // decode helpers
  logic [4:0]        ordc;
  logic              ord_big;
  logic [CW-1:0]     nsat;
  logic              fnd;
  logic [OW-1:0]     fidx;
  logic [ADDR_W-1:0] diff;
  logic              outside;
  logic [OW-1:0]     best;
  logic [WW-1:0]     blk;
  logic [WW-1:0]     rem;
  logic [WW-1:0]     idx_sum;
  logic [SW-1:0]     buddy;
  logic [SW-1:0]     split_page;
  logic              load_out;

  bpa_link_ram #(.DEPTH(MAX_PAGES), .WIDTH(PW)) u_link (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr == 1'b0);
  assign prdata = (paddr == 1'b0) ? region_base : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= '0;
    end else if (cfg_we) begin
      region_base <= pwdata;
    end
  end

  // request decode
  always_comb begin
    ordc    = order_of(n);
    ord_big = ordc > 5'(MAX_ORDER_VALUE);
    if (32'(n) > 32'(MAX_PAGES)) nsat = CW'(MAX_PAGES);
    else nsat = CW'(n);
    fnd  = 1'b0;
    fidx = '0;
    for (int k = MAX_ORDER_VALUE; k >= 0; k--) begin
      if ((5'(k) >= ordc) && (cnt[k] != '0)) begin
        fnd  = 1'b1;
        fidx = OW'(k);
      end
    end
    diff    = addr - region_base;
    outside = (addr < region_base) || ((diff >> PBW) >= ADDR_W'(region_pages));
  end

  // largest aligned block that fits at idx
  always_comb begin
    rem  = WW'(ninit) - WW'(idx);
    best = '0;
    for (int k = 1; k <= MAX_ORDER_VALUE; k++) begin
      if (((WW'(idx) & ((WW'(1) << k) - WW'(1))) == '0) && (rem >= (WW'(1) << k)))
        best = OW'(k);
    end
    blk     = WW'(1) << best;
    idx_sum = WW'(idx) + blk;
  end

  assign buddy      = page ^ (SW'(1) << c);
  assign split_page = page + (SW'(1) << (c - OW'(1)));

  // state register
  always_ff @(posedge clk) begin
    if (rst) st <= IDLE;
    else st <= st_next;
  end

  // next state and list controls
  always_comb begin
    st_next   = st;
    push_en   = 1'b0;
    push_page = '0;
    push_ord  = '0;
    hd_set    = 1'b0;
    hd_val    = ram_rdata;
    cnt_dec   = 1'b0;
    clear_all = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = cur;
    load_out  = 1'b0;
    unique case (st)
      IDLE: begin
        if (in_valid) st_next = DECODE;
      end
      DECODE: begin
        unique case (op)
          OP_INIT: begin
            clear_all = 1'b1;
            st_next   = (nsat == '0) ? DONE : INIT_RUN;
          end
          OP_ALLOC: begin
            if (n == '0 || ord_big || !fnd) begin
              st_next = DONE;
            end else begin
              ram_raddr = hd[fidx];
              st_next   = A_POP;
            end
          end
          OP_FREE: begin
            if (addr == '0 || addr[PBW-1:0] != '0 || n == '0 || ord_big || outside)
              st_next = DONE;
            else
              st_next = F_START;
          end
          default: st_next = DONE;
        endcase
      end
      INIT_RUN: begin
        push_en   = 1'b1;
        push_page = PW'(idx);
        push_ord  = best;
        if (idx_sum >= WW'(ninit)) st_next = DONE;
      end
      A_POP: begin
        hd_set  = 1'b1;
        cnt_dec = 1'b1;
        st_next = A_SPLIT;
      end
      A_SPLIT: begin
        if (c == ord) begin
          st_next = DONE;
        end else begin
          push_en   = split_page < SW'(MAX_PAGES);
          push_page = PW'(split_page);
          push_ord  = c - OW'(1);
        end
      end
      F_START: begin
        if (c == OW'(MAX_ORDER_VALUE)) begin
          push_en   = 1'b1;
          push_page = PW'(page);
          push_ord  = c;
          st_next   = DONE;
        end else begin
          st_next = F_CHECK;
        end
      end
      F_CHECK: begin
        if (wi == cnt[c]) begin
          push_en   = 1'b1;
          push_page = PW'(page);
          push_ord  = c;
          st_next   = DONE;
        end else if (SW'(cur) == buddy) begin
          st_next = F_UNLINK;
        end else begin
          st_next = F_NEXT;
        end
      end
      F_NEXT: begin
        st_next = F_CHECK;
      end
      F_UNLINK: begin
        if (wi == '0) begin
          hd_set = 1'b1;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = prev;
          ram_wdata = ram_rdata;
        end
        cnt_dec = 1'b1;
        st_next = F_START;
      end
      DONE: begin
        if (!out_valid || !out_stall) begin
          load_out = 1'b1;
          st_next  = IDLE;
        end
      end
      default: st_next = IDLE;
    endcase
    // a push links the page to the current head of its list
    if (push_en) begin
      ram_we    = 1'b1;
      ram_waddr = push_page;
      ram_wdata = (cnt[push_ord] != '0) ? hd[push_ord] : '0;
    end
  end

  // list heads, free counts and region size
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= MAX_ORDER_VALUE; k++) begin
        hd[k]  <= '0;
        cnt[k] <= '0;
      end
      region_pages <= '0;
    end else if (clear_all) begin
      for (int k = 0; k <= MAX_ORDER_VALUE; k++) begin
        hd[k]  <= '0;
        cnt[k] <= '0;
      end
      region_pages <= nsat;
    end else begin
      if (push_en) begin
        hd[push_ord] <= push_page;
        if (cnt[push_ord] != CW'(MAX_PAGES)) cnt[push_ord] <= cnt[push_ord] + CW'(1);
      end
      if (hd_set) hd[c] <= hd_val;
      if (cnt_dec) cnt[c] <= cnt[c] - CW'(1);
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    unique case (st)
      IDLE: begin
        op         <= operation;
        n          <= page_count;
        addr       <= address;
        res_status <= S_OK;
        res_addr   <= '0;
        res_order  <= '0;
      end
      DECODE: begin
        unique case (op)
          OP_INIT: begin
            ninit <= nsat;
            idx   <= '0;
            if (nsat == '0) res_status <= S_ZERO;
          end
          OP_ALLOC: begin
            if (n == '0) begin
              res_status <= S_ZERO;
            end else if (ord_big) begin
              res_status <= S_ORDER;
            end else begin
              res_order <= ORDER_W'(ordc);
              ord       <= OW'(ordc);
              c         <= fidx;
              page      <= SW'(hd[fidx]);
              if (!fnd) res_status <= S_OOM;
            end
          end
          OP_FREE: begin
            if (addr == '0) begin
              res_status <= S_NULL;
            end else if (addr[PBW-1:0] != '0) begin
              res_status <= S_MISALIGN;
            end else if (n == '0) begin
              res_status <= S_ZERO;
            end else if (ord_big) begin
              res_status <= S_ORDER;
            end else begin
              res_order <= ORDER_W'(ordc);
              c         <= OW'(ordc);
              page      <= SW'(diff >> PBW);
              if (outside) res_status <= S_OUTSIDE;
            end
          end
          default: ;
        endcase
      end
      INIT_RUN: idx <= CW'(idx_sum);
      A_POP:    res_addr <= region_base + (ADDR_W'(page) << PBW);
      A_SPLIT: begin
        if (c != ord) c <= c - OW'(1);
      end
      F_START: begin
        cur  <= hd[c];
        prev <= '0;
        wi   <= '0;
      end
      F_NEXT: begin
        prev <= cur;
        cur  <= ram_rdata;
        wi   <= wi + CW'(1);
      end
      F_UNLINK: begin
        if (buddy < page) page <= buddy;
        c <= c + OW'(1);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status        <= res_status;
      block_address <= res_addr;
      block_order   <= res_order;
    end
  end

  assign in_stall = (st != IDLE);

  // checks
  `BPA_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall,
    "block not busy after taking an item")
  `BPA_ASSERT_IMP(a_walk_bounded, clk, rst, st == F_CHECK, wi <= cnt[c],
    "list walk ran past the free count")
  `BPA_ASSERT_IMP(a_err_no_addr, clk, rst, out_valid && status != S_OK,
    block_address == '0, "error result carries a block address")

endmodule
